>>> rtl/mtep_pkg.sv
// Package for the track event parser: parse phase type, event kind and
// error codes, and the byte codes the decoder compares against.
// No dependencies.
package mtep_pkg;

   // parse phase of the byte decoder
   typedef enum logic [3:0] {
      PH_DELTA      = 4'd0,
      PH_STATUS     = 4'd1,
      PH_DATA       = 4'd2,
      PH_META_TYPE  = 4'd3,
      PH_META_LEN   = 4'd4,
      PH_META_DATA  = 4'd5,
      PH_SYSEX_LEN  = 4'd6,
      PH_SYSEX_DATA = 4'd7,
      PH_HALT       = 4'd8
   } phase_type;

   // event kind codes
   localparam logic [2:0] KIND_CHANNEL  = 3'd0;
   localparam logic [2:0] KIND_REALTIME = 3'd1;
   localparam logic [2:0] KIND_META     = 3'd2;
   localparam logic [2:0] KIND_SYSEX    = 3'd3;
   localparam logic [2:0] KIND_ERROR    = 3'd4;

   // error codes
   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_BAD_CMD     = 2'd1;
   localparam logic [1:0] ERR_NO_RUNNING  = 2'd2;
   localparam logic [1:0] ERR_BAD_RUNNING = 2'd3;

   // byte codes
   localparam logic [7:0] BYTE_META       = 8'hFF;
   localparam logic [7:0] BYTE_SYSEX      = 8'hF0;
   localparam logic [7:0] BYTE_SYSEX_ESC  = 8'hF7;
   localparam logic [7:0] BYTE_REALTIME   = 8'hF8;
   localparam logic [3:0] NIB_SYSTEM      = 4'hF;
   localparam logic [3:0] NIB_PROG_CHANGE = 4'hC;
   localparam logic [3:0] NIB_CHAN_PRESS  = 4'hD;

   // one result transaction
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  status;
      logic [3:0]  channel;
      logic [7:0]  data_first;
      logic [7:0]  data_second;
      logic [7:0]  meta_kind;
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        event_done;
      logic [31:0] delta_time;
      logic        used_running;
      logic [1:0]  error_code;
   } result_type;

endpackage

>>> rtl/midi_track_event_parser_top.sv
// Track event parser top level: byte-wise decoder and registered result.
// Depends on mtep_pkg.
//
// Usage:
//   The req_ channel carries one track-body byte per transaction; set
//   req_tuser on the first byte of a track to clear running status, delta
//   and the parse phase before that byte is decoded.
//   The rsp_ channel carries decoded events: one transaction per channel
//   message, real-time byte or empty meta/sysex event, and one per meta or
//   sysex payload byte. rsp_tlast marks the last transaction of an event and
//   every error. After an error the block swallows bytes silently until a
//   byte with req_tuser set arrives.
// Timing: a result is registered and appears on rsp_ in the cycle after the byte that caused it is accepted.
// Throughput: one byte per cycle while req_tready is high; the decode of each byte is one pass of
//   logic from the parser state registers into the result register.
// Stall: req_tready stays high while the result register is empty or being
//   taken; while a result waits and rsp_tready is low, input is held off.
// Reset: synchronous, clears the parse state and empties the result
//   register; no results are pending after reset.
module midi_track_event_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] track_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [7:0] status, [11:8] channel,
                                    // [19:12] data_first, [27:20] data_second,
                                    // [35:28] meta_kind, [43:36] payload_byte,
                                    // [44] payload_valid, [76:45] delta_time,
                                    // [77] used_running, [79:78] error_code
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast    // event_done
);

   // parser state
   mtep_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  running_byte_ff, running_byte_in;
   logic [7:0]  current_byte_ff, current_byte_in;
   logic [31:0] delta_ff, delta_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] seen_ff, seen_in;
   logic [1:0]  needed_ff, needed_in;
   logic [7:0]  held_data_ff, held_data_in;
   logic [7:0]  held_meta_ff, held_meta_in;
   logic        running_flag_ff, running_flag_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   mtep_pkg::result_type   rsp_ff;
   mtep_pkg::result_type   res;
   logic                   res_valid;
   logic                   finish_evt;

   logic accept;
   logic [7:0] b;

   // state as seen by this byte (track start clears it first)
   mtep_pkg::phase_type phase_cur;
   logic [7:0]  running_cur, current_cur, held_data_cur, held_meta_cur;
   logic [31:0] delta_cur, length_cur, seen_cur;
   logic [1:0]  needed_cur;
   logic        running_flag_cur;

   // derived decode terms
   logic [3:0]  b_hi, run_hi;
   logic        run_one_byte, cmd_one_byte;
   logic [31:0] delta_shift, length_shift, seen_inc;
   logic        seen_reached;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;

   assign phase_cur        = req_tuser ? mtep_pkg::PH_DELTA : phase_ff;
   assign running_cur      = req_tuser ? 8'd0  : running_byte_ff;
   assign current_cur      = req_tuser ? 8'd0  : current_byte_ff;
   assign held_data_cur    = req_tuser ? 8'd0  : held_data_ff;
   assign held_meta_cur    = req_tuser ? 8'd0  : held_meta_ff;
   assign delta_cur        = req_tuser ? 32'd0 : delta_ff;
   assign length_cur       = req_tuser ? 32'd0 : length_ff;
   assign seen_cur         = req_tuser ? 32'd0 : seen_ff;
   assign needed_cur       = req_tuser ? 2'd0  : needed_ff;
   assign running_flag_cur = req_tuser ? 1'b0  : running_flag_ff;

   assign b_hi         = b[7:4];
   assign run_hi       = running_cur[7:4];
   assign run_one_byte = (run_hi == mtep_pkg::NIB_PROG_CHANGE) ||
                         (run_hi == mtep_pkg::NIB_CHAN_PRESS);
   assign cmd_one_byte = (b_hi == mtep_pkg::NIB_PROG_CHANGE) ||
                         (b_hi == mtep_pkg::NIB_CHAN_PRESS);
   assign delta_shift  = {delta_cur[24:0], b[6:0]};
   assign length_shift = {length_cur[24:0], b[6:0]};
   assign seen_inc     = seen_cur + 32'd1;
   assign seen_reached = (seen_inc >= length_cur);

   // next parse phase
   always_comb begin
      phase_in = phase_cur;
      unique case (phase_cur) inside
         mtep_pkg::PH_DELTA: begin
            if (!b[7]) phase_in = mtep_pkg::PH_STATUS;
         end
         mtep_pkg::PH_STATUS: begin
            if (b[7]) begin
               if (b == mtep_pkg::BYTE_META) begin
                  phase_in = mtep_pkg::PH_META_TYPE;
               end else if (b == mtep_pkg::BYTE_SYSEX || b == mtep_pkg::BYTE_SYSEX_ESC) begin
                  phase_in = mtep_pkg::PH_SYSEX_LEN;
               end else if (b >= mtep_pkg::BYTE_REALTIME) begin
                  phase_in = mtep_pkg::PH_DELTA;
               end else if (b_hi == mtep_pkg::NIB_SYSTEM) begin
                  phase_in = mtep_pkg::PH_HALT;
               end else begin
                  phase_in = mtep_pkg::PH_DATA;
               end
            end else if (running_cur == 8'd0 || run_hi == mtep_pkg::NIB_SYSTEM) begin
               phase_in = mtep_pkg::PH_HALT;
            end else if (run_one_byte) begin
               phase_in = mtep_pkg::PH_DELTA;
            end else begin
               phase_in = mtep_pkg::PH_DATA;
            end
         end
         mtep_pkg::PH_DATA: begin
            if (!(needed_cur == 2'd2 && seen_cur == 32'd0)) phase_in = mtep_pkg::PH_DELTA;
         end
         mtep_pkg::PH_META_TYPE: begin
            phase_in = mtep_pkg::PH_META_LEN;
         end
         mtep_pkg::PH_META_LEN: begin
            if (!b[7]) begin
               phase_in = (length_shift != 32'd0) ? mtep_pkg::PH_META_DATA
                                                  : mtep_pkg::PH_DELTA;
            end
         end
         mtep_pkg::PH_SYSEX_LEN: begin
            if (!b[7]) begin
               phase_in = (length_shift != 32'd0) ? mtep_pkg::PH_SYSEX_DATA
                                                  : mtep_pkg::PH_DELTA;
            end
         end
         mtep_pkg::PH_META_DATA, mtep_pkg::PH_SYSEX_DATA: begin
            if (seen_reached) phase_in = mtep_pkg::PH_DELTA;
         end
         mtep_pkg::PH_HALT: begin
            phase_in = mtep_pkg::PH_HALT;
         end
         default: phase_in = mtep_pkg::PH_HALT;
      endcase
   end

   // result of this byte
   always_comb begin
      res            = '0;
      res.delta_time = delta_cur;
      res_valid      = 1'b0;
      finish_evt     = 1'b0;
      case (phase_cur)
         mtep_pkg::PH_STATUS: begin
            if (b[7]) begin
               if (b == mtep_pkg::BYTE_META || b == mtep_pkg::BYTE_SYSEX ||
                   b == mtep_pkg::BYTE_SYSEX_ESC) begin
                  res_valid = 1'b0;
               end else if (b >= mtep_pkg::BYTE_REALTIME) begin
                  res_valid      = 1'b1;
                  finish_evt     = 1'b1;
                  res.kind       = mtep_pkg::KIND_REALTIME;
                  res.status     = b;
                  res.channel    = b[3:0];
                  res.event_done = 1'b1;
               end else if (b_hi == mtep_pkg::NIB_SYSTEM) begin
                  res_valid      = 1'b1;
                  res.kind       = mtep_pkg::KIND_ERROR;
                  res.status     = b;
                  res.channel    = b[3:0];
                  res.event_done = 1'b1;
                  res.error_code = mtep_pkg::ERR_BAD_CMD;
               end
            end else if (running_cur == 8'd0) begin
               res_valid      = 1'b1;
               res.kind       = mtep_pkg::KIND_ERROR;
               res.event_done = 1'b1;
               res.error_code = mtep_pkg::ERR_NO_RUNNING;
            end else if (run_hi == mtep_pkg::NIB_SYSTEM) begin
               res_valid      = 1'b1;
               res.kind       = mtep_pkg::KIND_ERROR;
               res.status     = running_cur;
               res.channel    = running_cur[3:0];
               res.event_done = 1'b1;
               res.error_code = mtep_pkg::ERR_BAD_RUNNING;
            end else if (run_one_byte) begin
               res_valid        = 1'b1;
               finish_evt       = 1'b1;
               res.kind         = mtep_pkg::KIND_CHANNEL;
               res.status       = running_cur;
               res.channel      = running_cur[3:0];
               res.data_first   = b;
               res.used_running = 1'b1;
               res.event_done   = 1'b1;
            end
         end
         mtep_pkg::PH_DATA: begin
            if (!(needed_cur == 2'd2 && seen_cur == 32'd0)) begin
               res_valid        = 1'b1;
               finish_evt       = 1'b1;
               res.kind         = mtep_pkg::KIND_CHANNEL;
               res.status       = current_cur;
               res.channel      = current_cur[3:0];
               res.data_first   = (needed_cur == 2'd2) ? held_data_cur : b;
               res.data_second  = (needed_cur == 2'd2) ? b : 8'd0;
               res.used_running = running_flag_cur;
               res.event_done   = 1'b1;
            end
         end
         mtep_pkg::PH_META_LEN: begin
            if (!b[7] && length_shift == 32'd0) begin
               res_valid      = 1'b1;
               finish_evt     = 1'b1;
               res.kind       = mtep_pkg::KIND_META;
               res.status     = mtep_pkg::BYTE_META;
               res.channel    = mtep_pkg::BYTE_META[3:0];
               res.meta_kind  = held_meta_cur;
               res.event_done = 1'b1;
            end
         end
         mtep_pkg::PH_SYSEX_LEN: begin
            if (!b[7] && length_shift == 32'd0) begin
               res_valid      = 1'b1;
               finish_evt     = 1'b1;
               res.kind       = mtep_pkg::KIND_SYSEX;
               res.status     = current_cur;
               res.channel    = current_cur[3:0];
               res.event_done = 1'b1;
            end
         end
         mtep_pkg::PH_META_DATA: begin
            res_valid         = 1'b1;
            finish_evt        = seen_reached;
            res.kind          = mtep_pkg::KIND_META;
            res.status        = mtep_pkg::BYTE_META;
            res.channel       = mtep_pkg::BYTE_META[3:0];
            res.meta_kind     = held_meta_cur;
            res.payload_byte  = b;
            res.payload_valid = 1'b1;
            res.event_done    = seen_reached;
         end
         mtep_pkg::PH_SYSEX_DATA: begin
            res_valid         = 1'b1;
            finish_evt        = seen_reached;
            res.kind          = mtep_pkg::KIND_SYSEX;
            res.status        = current_cur;
            res.channel       = current_cur[3:0];
            res.payload_byte  = b;
            res.payload_valid = 1'b1;
            res.event_done    = seen_reached;
         end
         default: res_valid = 1'b0;
      endcase
   end

   // datapath registers next values
   always_comb begin
      running_byte_in = running_cur;
      current_byte_in = current_cur;
      delta_in        = delta_cur;
      length_in       = length_cur;
      seen_in         = seen_cur;
      needed_in       = needed_cur;
      held_data_in    = held_data_cur;
      held_meta_in    = held_meta_cur;
      running_flag_in = running_flag_cur;
      case (phase_cur) inside
         mtep_pkg::PH_DELTA: begin
            delta_in = delta_shift;
         end
         mtep_pkg::PH_STATUS: begin
            if (b[7]) begin
               current_byte_in = b;
               running_byte_in = b;
               running_flag_in = 1'b0;
               if (b == mtep_pkg::BYTE_SYSEX || b == mtep_pkg::BYTE_SYSEX_ESC) begin
                  length_in = 32'd0;
               end else if (b < mtep_pkg::BYTE_REALTIME && b != mtep_pkg::BYTE_META &&
                            b_hi != mtep_pkg::NIB_SYSTEM) begin
                  needed_in = cmd_one_byte ? 2'd1 : 2'd2;
                  seen_in   = 32'd0;
               end
            end else if (running_cur != 8'd0 && run_hi != mtep_pkg::NIB_SYSTEM) begin
               current_byte_in = running_cur;
               running_flag_in = 1'b1;
               if (run_one_byte) begin
                  needed_in = 2'd1;
               end else begin
                  needed_in    = 2'd2;
                  held_data_in = b;
                  seen_in      = 32'd1;
               end
            end
         end
         mtep_pkg::PH_DATA: begin
            if (needed_cur == 2'd2 && seen_cur == 32'd0) begin
               held_data_in = b;
               seen_in      = 32'd1;
            end
         end
         mtep_pkg::PH_META_TYPE: begin
            held_meta_in = b;
            length_in    = 32'd0;
         end
         mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
            length_in = length_shift;
            if (!b[7] && length_shift != 32'd0) seen_in = 32'd0;
         end
         mtep_pkg::PH_META_DATA, mtep_pkg::PH_SYSEX_DATA: begin
            seen_in = seen_inc;
         end
         default: seen_in = seen_cur;
      endcase
      // end of a good event clears delta and the running-status mark
      if (finish_evt) begin
         delta_in        = 32'd0;
         running_flag_in = 1'b0;
      end
   end

   // result register valid: load on accepted byte, clear when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = res_valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= mtep_pkg::PH_DELTA;
         running_byte_ff <= 8'd0;
         current_byte_ff <= 8'd0;
         delta_ff        <= 32'd0;
         length_ff       <= 32'd0;
         seen_ff         <= 32'd0;
         needed_ff       <= 2'd0;
         held_data_ff    <= 8'd0;
         held_meta_ff    <= 8'd0;
         running_flag_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff        <= phase_in;
            running_byte_ff <= running_byte_in;
            current_byte_ff <= current_byte_in;
            delta_ff        <= delta_in;
            length_ff       <= length_in;
            seen_ff         <= seen_in;
            needed_ff       <= needed_in;
            held_data_ff    <= held_data_in;
            held_meta_ff    <= held_meta_in;
            running_flag_ff <= running_flag_in;
         end
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         rsp_ff <= res;
      end
   end

   // output packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.event_done;
   assign rsp_tdata  = {rsp_ff.error_code, rsp_ff.used_running, rsp_ff.delta_time,
                        rsp_ff.payload_valid, rsp_ff.payload_byte, rsp_ff.meta_kind,
                        rsp_ff.data_second, rsp_ff.data_first, rsp_ff.channel,
                        rsp_ff.status};

endmodule

>>> sim/midi_track_event_parser_top_tb.sv
// Self-checking bench for midi_track_event_parser_top: byte streams of track bodies in,
// decoded events out, checked against an in-bench event predictor.
// Depends on mtep_pkg and the parser top level.
module midi_track_event_parser_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES = 1400;
   localparam int QUIET_TAIL   = 200;
   localparam int CYCLE_LIMIT  = 500000;

   // Event predictor and store of expected events
   class event_scoreboard;
      mtep_pkg::phase_type   phase;
      logic [7:0]            run_status;
      logic [7:0]            cur_status;
      logic [7:0]            held_data;
      logic [7:0]            held_meta;
      logic [31:0]           delta;
      logic [31:0]           len;
      logic [31:0]           seen;
      logic [1:0]            need;
      logic                  run_used;
      mtep_pkg::result_type  expected_q[$];
      int                    mismatches;

      function new();
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         phase      = mtep_pkg::PH_DELTA;
         run_status = 8'h00;
         cur_status = 8'h00;
         held_data  = 8'h00;
         held_meta  = 8'h00;
         delta      = '0;
         len        = '0;
         seen       = '0;
         need       = 2'd0;
         run_used   = 1'b0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // event finished: back to delta phase, delta cleared
      function void end_event();
         phase    = mtep_pkg::PH_DELTA;
         delta    = '0;
         run_used = 1'b0;
      endfunction

      function mtep_pkg::result_type open_result(logic [2:0] kind, logic [7:0] st);
         mtep_pkg::result_type r;
         r            = '0;
         r.kind       = kind;
         r.status     = st;
         r.channel    = st[3:0];
         r.delta_time = delta;
         return r;
      endfunction

      function mtep_pkg::result_type error_result(logic [1:0] code, logic [7:0] st);
         mtep_pkg::result_type r;
         r            = open_result(mtep_pkg::KIND_ERROR, st);
         r.event_done = 1'b1;
         r.error_code = code;
         phase        = mtep_pkg::PH_HALT;
         return r;
      endfunction

      function mtep_pkg::result_type channel_result(logic [7:0] d1, logic [7:0] d2);
         mtep_pkg::result_type r;
         r              = open_result(mtep_pkg::KIND_CHANNEL, cur_status);
         r.data_first   = d1;
         r.data_second  = d2;
         r.used_running = run_used;
         r.event_done   = 1'b1;
         end_event();
         return r;
      endfunction

      // meta or sysex result frame, depends on the current phase
      function mtep_pkg::result_type payload_base();
         mtep_pkg::result_type r;
         if (phase == mtep_pkg::PH_META_LEN || phase == mtep_pkg::PH_META_DATA) begin
            r           = open_result(mtep_pkg::KIND_META, mtep_pkg::BYTE_META);
            r.meta_kind = held_meta;
         end else begin
            r = open_result(mtep_pkg::KIND_SYSEX, cur_status);
         end
         return r;
      endfunction

      // predict the event (if any) caused by one accepted byte
      function void note_byte(logic [7:0] b, logic ts);
         mtep_pkg::result_type r;
         bit                   hit;
         hit = 1'b0;
         r   = '0;
         if (ts)
            clear();
         case (phase) inside
            mtep_pkg::PH_DELTA: begin
               delta = {delta[24:0], b[6:0]};
               if (!b[7])
                  phase = mtep_pkg::PH_STATUS;
            end
            mtep_pkg::PH_STATUS: begin
               if (b[7]) begin
                  cur_status = b;
                  run_status = b;
                  run_used   = 1'b0;
                  if (b == mtep_pkg::BYTE_META) begin
                     phase = mtep_pkg::PH_META_TYPE;
                  end else if (b == mtep_pkg::BYTE_SYSEX || b == mtep_pkg::BYTE_SYSEX_ESC) begin
                     len   = '0;
                     phase = mtep_pkg::PH_SYSEX_LEN;
                  end else if (b >= mtep_pkg::BYTE_REALTIME) begin
                     r            = open_result(mtep_pkg::KIND_REALTIME, b);
                     r.event_done = 1'b1;
                     end_event();
                     hit = 1'b1;
                  end else if (b[7:4] == mtep_pkg::NIB_SYSTEM) begin
                     r   = error_result(mtep_pkg::ERR_BAD_CMD, b);
                     hit = 1'b1;
                  end else begin
                     need  = (b[7:4] == mtep_pkg::NIB_PROG_CHANGE ||
                              b[7:4] == mtep_pkg::NIB_CHAN_PRESS) ? 2'd1 : 2'd2;
                     seen  = '0;
                     phase = mtep_pkg::PH_DATA;
                  end
               end else if (run_status == 8'h00) begin
                  r   = error_result(mtep_pkg::ERR_NO_RUNNING, 8'h00);
                  hit = 1'b1;
               end else if (run_status[7:4] == mtep_pkg::NIB_SYSTEM) begin
                  r   = error_result(mtep_pkg::ERR_BAD_RUNNING, run_status);
                  hit = 1'b1;
               end else begin
                  cur_status = run_status;
                  run_used   = 1'b1;
                  if (run_status[7:4] == mtep_pkg::NIB_PROG_CHANGE ||
                      run_status[7:4] == mtep_pkg::NIB_CHAN_PRESS) begin
                     // one-byte message under running status ends right here
                     need = 2'd1;
                     r    = channel_result(b, 8'h00);
                     hit  = 1'b1;
                  end else begin
                     need      = 2'd2;
                     held_data = b;
                     seen      = 32'd1;
                     phase     = mtep_pkg::PH_DATA;
                  end
               end
            end
            mtep_pkg::PH_DATA: begin
               if (need == 2'd2 && seen == 0) begin
                  held_data = b;
                  seen      = 32'd1;
               end else if (need == 2'd2) begin
                  r   = channel_result(held_data, b);
                  hit = 1'b1;
               end else begin
                  r   = channel_result(b, 8'h00);
                  hit = 1'b1;
               end
            end
            mtep_pkg::PH_META_TYPE: begin
               held_meta = b;
               len       = '0;
               phase     = mtep_pkg::PH_META_LEN;
            end
            mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
               len = {len[24:0], b[6:0]};
               if (!b[7]) begin
                  if (len != 0) begin
                     seen  = '0;
                     phase = (phase == mtep_pkg::PH_META_LEN) ? mtep_pkg::PH_META_DATA
                                                              : mtep_pkg::PH_SYSEX_DATA;
                  end else begin
                     // empty meta / sysex completes on its length byte
                     r            = payload_base();
                     r.event_done = 1'b1;
                     end_event();
                     hit = 1'b1;
                  end
               end
            end
            mtep_pkg::PH_META_DATA, mtep_pkg::PH_SYSEX_DATA: begin
               seen            = seen + 32'd1;
               r               = payload_base();
               r.payload_byte  = b;
               r.payload_valid = 1'b1;
               if (seen >= len) begin
                  r.event_done = 1'b1;
                  end_event();
               end
               hit = 1'b1;
            end
            default: ;  // halted until a track start
         endcase
         if (hit)
            expected_q.insert(expected_q.size(), r);
      endfunction

      function string show(mtep_pkg::result_type r);
         return {$sformatf("kind=%0d st=%h ch=%h d1=%h d2=%h mk=%h ",
                           r.kind, r.status, r.channel, r.data_first, r.data_second,
                           r.meta_kind),
                 $sformatf("pb=%h pv=%b done=%b dt=%h run=%b err=%0d",
                           r.payload_byte, r.payload_valid, r.event_done,
                           r.delta_time, r.used_running, r.error_code)};
      endfunction

      function void report(string what, mtep_pkg::result_type exp_evt,
                           mtep_pkg::result_type act_evt);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%s", what);
            $display("  expected %s", show(exp_evt));
            $display("  actual   %s", show(act_evt));
         end
      endfunction

      // compare one observed event with the oldest expectation
      function void check_event(mtep_pkg::result_type act_evt);
         mtep_pkg::result_type exp_evt;
         if (expected_q.size() == 0) begin
            report("event with nothing expected", '0, act_evt);
         end else begin
            exp_evt = expected_q.pop_front();
            if (act_evt !== exp_evt)
               report("event mismatch", exp_evt, act_evt);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   event_scoreboard sb;
   int unsigned     bytes_taken = 0;
   int unsigned     bytes_sent  = 0;
   int unsigned     cycles      = 0;
   int unsigned     stall_left  = 0;
   bit              send_gaps;
   bit              recv_gaps;
   bit              next_ts;
   logic [7:0]      gen_running;

   midi_track_event_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // monitor: take accepted transactions on both channels
   always @(posedge clock) begin : monitor
      mtep_pkg::result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_byte(req_tdata, req_tuser);
            bytes_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got               = '0;
            got.kind          = rsp_tuser;
            got.status        = rsp_tdata[7:0];
            got.channel       = rsp_tdata[11:8];
            got.data_first    = rsp_tdata[19:12];
            got.data_second   = rsp_tdata[27:20];
            got.meta_kind     = rsp_tdata[35:28];
            got.payload_byte  = rsp_tdata[43:36];
            got.payload_valid = rsp_tdata[44];
            got.delta_time    = rsp_tdata[76:45];
            got.used_running  = rsp_tdata[77];
            got.error_code    = rsp_tdata[79:78];
            got.event_done    = rsp_tlast;
            sb.check_event(got);
         end
      end
   end

   // result side back-pressure in bursts of random length
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 6) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // drive one byte; called and returns at a falling edge
   task automatic send_byte(logic [7:0] b, logic ts);
      int unsigned target;
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      target = bytes_taken + 1;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= ts;
      do @(negedge clock); while (bytes_taken < target);
   endtask

   task automatic push_byte(logic [7:0] b);
      send_byte(b, next_ts);
      next_ts = 1'b0;
      bytes_sent++;
   endtask

   // variable-length quantity in nb bytes, high groups first
   task automatic put_vlq(logic [31:0] v, int nb);
      logic [34:0] w;
      int          i;
      w = {3'b000, v};
      for (i = nb - 1; i > 0; i--)
         push_byte({1'b1, w[7*i +: 7]});
      push_byte({1'b0, w[6:0]});
   endtask

   task automatic put_length(int len, bit pad);
      int nb;
      nb = 1;
      if (len > 127)
         nb = 2;
      if (len > 16383)
         nb = 3;
      if (pad)
         nb++;
      put_vlq(len, nb);
   endtask

   // random delta, mostly short, sometimes past 32 bits
   task automatic put_delta();
      int n;
      int r;
      r = $urandom_range(0, 19);
      n = (r < 12) ? 1 : (r < 17) ? 2 : (r < 19) ? 3 : $urandom_range(4, 6);
      repeat (n - 1)
         push_byte({1'b1, 7'($urandom_range(0, 127))});
      push_byte({1'b0, 7'($urandom_range(0, 127))});
   endtask

   function automatic logic [7:0] data_value();
      if ($urandom_range(0, 7) == 0)
         return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 127));
   endfunction

   function automatic int random_len();
      int r;
      r = $urandom_range(0, 24);
      if (r < 5)
         return 0;
      if (r == 24)
         return $urandom_range(7, 140);
      return $urandom_range(1, 6);
   endfunction

   task automatic put_payload_event(logic [7:0] st, logic [7:0] kind, int len);
      push_byte(st);
      if (st == mtep_pkg::BYTE_META)
         push_byte(kind);
      put_length(len, $urandom_range(0, 7) == 0);
      repeat (len)
         push_byte(8'($urandom_range(0, 255)));
      gen_running = st;
   endtask

   // channel message, with or without running status
   task automatic put_channel();
      logic [3:0] hi;
      logic [3:0] nib;
      logic [7:0] st;
      hi = gen_running[7:4];
      if (hi >= 4'h8 && hi <= 4'hE && $urandom_range(0, 2) == 0) begin
         push_byte(8'($urandom_range(0, 127)));
         if (hi != mtep_pkg::NIB_PROG_CHANGE && hi != mtep_pkg::NIB_CHAN_PRESS)
            push_byte(data_value());
      end else begin
         nib = 4'($urandom_range(8, 14));
         st  = {nib, 4'($urandom_range(0, 15))};
         push_byte(st);
         push_byte(data_value());
         if (nib != mtep_pkg::NIB_PROG_CHANGE && nib != mtep_pkg::NIB_CHAN_PRESS)
            push_byte(data_value());
         gen_running = st;
      end
   endtask

   task automatic put_realtime();
      logic [7:0] st;
      st = 8'($urandom_range(8'hF8, 8'hFE));
      push_byte(st);
      gen_running = st;
   endtask

   // one of the three error kinds, some ignored bytes, then a new track
   task automatic put_error();
      case ($urandom_range(0, 2))
         0: begin
            put_delta();
            push_byte(8'($urandom_range(8'hF1, 8'hF6)));
         end
         1: begin
            next_ts = 1'b1;
            put_delta();
            push_byte(8'($urandom_range(0, 127)));
         end
         default: begin
            put_delta();
            if ($urandom_range(0, 1))
               put_realtime();
            else
               put_payload_event(mtep_pkg::BYTE_META, 8'($urandom_range(0, 255)), 0);
            put_delta();
            push_byte(8'($urandom_range(0, 127)));
         end
      endcase
      repeat ($urandom_range(0, 3))
         push_byte(8'($urandom_range(0, 255)));
      next_ts     = 1'b1;
      gen_running = 8'h00;
   endtask

   task automatic put_noise();
      repeat ($urandom_range(1, 4)) begin
         next_ts = ($urandom_range(0, 7) == 0);
         push_byte(8'($urandom_range(0, 255)));
      end
      next_ts     = 1'b1;
      gen_running = 8'h00;
   endtask

   // short directed pass over the corner cases
   task automatic directed_pass();
      next_ts = 1'b1;
      put_vlq(32'd0, 1);
      push_byte(8'h90); push_byte(8'h00); push_byte(8'h7F);
      put_vlq(32'h0FFFFFFF, 4);
      push_byte(8'h7F); push_byte(8'h00);               // running two-byte
      put_vlq(32'hFFFFFFFF, 5);                         // wraps at 32 bits
      push_byte(8'hC5); push_byte(8'h7F);
      put_vlq(32'd0, 2);
      push_byte(8'h12);                                 // running one-byte
      put_vlq(32'd1, 1);
      push_byte(8'hDF); push_byte(8'h00);
      put_vlq(32'd3, 1);
      push_byte(8'hEF); push_byte(8'hFF); push_byte(8'h80);
      put_vlq(32'd0, 1); push_byte(8'h80); push_byte(8'h3C); push_byte(8'h40);
      put_vlq(32'd0, 1); push_byte(8'hA3); push_byte(8'h01); push_byte(8'h02);
      put_vlq(32'd0, 1); push_byte(8'hB9); push_byte(8'h07); push_byte(8'h64);
      put_vlq(32'd5, 1); put_payload_event(mtep_pkg::BYTE_META, 8'h2F, 0);
      put_vlq(32'd0, 1); push_byte(mtep_pkg::BYTE_META); push_byte(8'h01);
      put_vlq(32'd3, 2);                                // padded length
      push_byte(8'h41); push_byte(8'hFF); push_byte(8'h00);
      put_vlq(32'd0, 1); put_payload_event(mtep_pkg::BYTE_SYSEX, 8'h00, 0);
      put_vlq(32'd2, 1); put_payload_event(mtep_pkg::BYTE_SYSEX_ESC, 8'h00, 2);
      put_vlq(32'd0, 1); put_payload_event(mtep_pkg::BYTE_SYSEX, 8'h00, 130);
      put_vlq(32'd0, 1); push_byte(mtep_pkg::BYTE_REALTIME);
      put_vlq(32'd7, 1); push_byte(8'hFE);
      put_vlq(32'd9, 1); push_byte(8'h40);              // running system status
      push_byte(8'h90); push_byte(8'h40);               // ignored while halted
      next_ts = 1'b1;
      put_vlq(32'd2, 1); push_byte(8'hF1);              // bad command
      push_byte(8'h00);
      next_ts = 1'b1;
      put_vlq(32'd4, 1); push_byte(8'h55);              // no running status
      next_ts = 1'b1;
      put_vlq(32'd0, 1); push_byte(8'hF6);
      next_ts = 1'b1;
      put_vlq(32'd0, 1); put_payload_event(mtep_pkg::BYTE_META, 8'h51, 0);
      put_vlq(32'd0, 1); push_byte(8'h22);              // running after meta
      next_ts     = 1'b1;
      gen_running = 8'h00;
   endtask

   // stimulus and end of run
   initial begin
      int unsigned start_count;
      int          pick;
      sb          = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tuser   = 1'b0;
      rsp_tready  = 1'b0;
      send_gaps   = 1'b1;
      recv_gaps   = 1'b1;
      next_ts     = 1'b0;
      gen_running = 8'h00;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_pass();

      start_count = bytes_sent;
      while (bytes_sent - start_count < RANDOM_BYTES) begin
         if (bytes_sent - start_count >= RANDOM_BYTES - QUIET_TAIL) begin
            send_gaps = 1'b0;
            recv_gaps = 1'b0;
         end else if ($urandom_range(0, 39) == 0) begin
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 29) == 0) begin
            next_ts     = 1'b1;
            gen_running = 8'h00;
         end
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            put_delta();
            put_channel();
         end else if (pick < 60) begin
            put_delta();
            put_realtime();
         end else if (pick < 72) begin
            put_delta();
            put_payload_event(mtep_pkg::BYTE_META, 8'($urandom_range(0, 255)),
                              random_len());
         end else if (pick < 82) begin
            put_delta();
            put_payload_event($urandom_range(0, 1) ? mtep_pkg::BYTE_SYSEX
                                                   : mtep_pkg::BYTE_SYSEX_ESC,
                              8'h00, random_len());
         end else if (pick < 90) begin
            put_error();
         end else begin
            put_noise();
         end
      end
      req_tvalid <= 1'b0;

      // drain, then keep running a little for anything late
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> sim.f
rtl/mtep_pkg.sv
rtl/midi_track_event_parser_top.sv
sim/midi_track_event_parser_top_tb.sv
